### hw/rtl/rhit_pkg.sv
`default_nettype none
package rhit_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         corner;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } rhit_in_t;

  typedef struct packed {
    logic               hit;
    logic               parallel;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic signed [31:0] iz;
  } rhit_out_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // multiplier operand A sources
  typedef enum logic [2:0] {
    OPA_U, OPA_N, OPA_DLO, OPA_DHI, OPA_AM, OPA_AB, OPA_AD
  } opa_t;

  // multiplier operand B sources
  typedef enum logic [2:0] {
    OPB_V, OPB_C1, OPB_E, OPB_EABS, OPB_AB, OPB_AD
  } opb_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_N0, DST_N1, DST_N2, DST_D, DST_NE,
    DST_PAB, DST_PAD, DST_AAB, DST_AAD
  } dst_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       mac;
    opa_t       a_sel;
    logic [1:0] a_idx;
    opb_t       b_sel;
    logic [1:0] b_idx;
    logic       clr;
    logic       neg;
    logic       shift;
    dst_t       dst;
    logic       div_start;
    logic       m_store;
    logic [1:0] coord;
    logic       fin_par;
    logic       fin_hit;
  } rhit_cmd_t;

  typedef struct packed {
    logic ne_zero;
    logic div_done;
  } rhit_stat_t;

endpackage
`default_nettype wire

### hw/rtl/rhit_div.sv
`default_nettype none
module rhit_div #(
  parameter int WIDTH = 70
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] num,
  input  wire logic [WIDTH-1:0] den,
  output logic                  done,
  output logic      [WIDTH-1:0] quot
);

  localparam int CNTW = $clog2(WIDTH + 1);

  logic [CNTW-1:0] cnt;
  logic            running;
  logic [WIDTH-1:0] rem;
  logic [WIDTH:0]   rem_sh;
  logic             fits;

  // restoring division, one quotient bit per cycle; quot doubles as the dividend shifter
  assign rem_sh = {rem, quot[WIDTH-1]};
  assign fits   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNTW'(WIDTH);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (running) begin
      rem  <= fits ? WIDTH'(rem_sh - {1'b0, den}) : rem_sh[WIDTH-1:0];
      quot <= {quot[WIDTH-2:0], fits};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rhit_ctrl.sv
`default_nettype none
module rhit_ctrl
  import rhit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       item_cmd,
  input  rhit_stat_t      stat,
  output rhit_cmd_t       cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_CHECK, S_NUMHI, S_NUMLO, S_DIVGO, S_DIVW, S_FIN
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'd11;

  state_t     state;
  logic [3:0] step;
  logic [1:0] coord;
  logic       hit_phase;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      coord     <= '0;
      hit_phase <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && item_cmd == CMD_TEST) begin
            state     <= S_SETUP;
            step      <= '0;
            hit_phase <= 1'b0;
          end
        end
        S_SETUP: begin
          if (step == LAST_STEP) begin
            step <= '0;
            if (hit_phase) begin
              state <= S_FIN;
            end else begin
              state <= S_CHECK;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CHECK: begin
          coord <= '0;
          if (stat.ne_zero) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_NUMHI;
          end
        end
        S_NUMHI: state <= S_NUMLO;
        S_NUMLO: state <= S_DIVGO;
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (stat.div_done) begin
            coord <= coord + 1'b1;
            if (coord == 2'd2) begin
              state     <= S_SETUP;
              hit_phase <= 1'b1;
              step      <= '0;
            end else begin
              state <= S_NUMHI;
            end
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // micro-program: each step is one multiply-accumulate
  always_comb begin
    cmd         = '0;
    cmd.a_sel   = OPA_U;
    cmd.b_sel   = OPB_V;
    cmd.dst     = DST_NONE;
    cmd.coord   = coord;
    cmd.load    = accept && item_cmd == CMD_LOAD;
    cmd.capture = accept && item_cmd == CMD_TEST;
    case (state)
      S_SETUP: begin
        cmd.mac = 1'b1;
        if (!hit_phase) begin
          case (step)
            4'd0:  begin cmd.a_sel = OPA_U; cmd.a_idx = 2'd1; cmd.b_sel = OPB_V;
                         cmd.b_idx = 2'd2; cmd.clr = 1'b1; end
            4'd1:  begin cmd.a_sel = OPA_U; cmd.a_idx = 2'd2; cmd.b_sel = OPB_V;
                         cmd.b_idx = 2'd1; cmd.neg = 1'b1; cmd.dst = DST_N0; end
            4'd2:  begin cmd.a_sel = OPA_U; cmd.a_idx = 2'd2; cmd.b_sel = OPB_V;
                         cmd.b_idx = 2'd0; cmd.clr = 1'b1; end
            4'd3:  begin cmd.a_sel = OPA_U; cmd.a_idx = 2'd0; cmd.b_sel = OPB_V;
                         cmd.b_idx = 2'd2; cmd.neg = 1'b1; cmd.dst = DST_N1; end
            4'd4:  begin cmd.a_sel = OPA_U; cmd.a_idx = 2'd0; cmd.b_sel = OPB_V;
                         cmd.b_idx = 2'd1; cmd.clr = 1'b1; end
            4'd5:  begin cmd.a_sel = OPA_U; cmd.a_idx = 2'd1; cmd.b_sel = OPB_V;
                         cmd.b_idx = 2'd0; cmd.neg = 1'b1; cmd.dst = DST_N2; end
            4'd6:  begin cmd.a_sel = OPA_N; cmd.a_idx = 2'd0; cmd.b_sel = OPB_C1;
                         cmd.b_idx = 2'd0; cmd.clr = 1'b1; end
            4'd7:  begin cmd.a_sel = OPA_N; cmd.a_idx = 2'd1; cmd.b_sel = OPB_C1;
                         cmd.b_idx = 2'd1; end
            4'd8:  begin cmd.a_sel = OPA_N; cmd.a_idx = 2'd2; cmd.b_sel = OPB_C1;
                         cmd.b_idx = 2'd2; cmd.dst = DST_D; end
            4'd9:  begin cmd.a_sel = OPA_N; cmd.a_idx = 2'd0; cmd.b_sel = OPB_E;
                         cmd.b_idx = 2'd0; cmd.clr = 1'b1; end
            4'd10: begin cmd.a_sel = OPA_N; cmd.a_idx = 2'd1; cmd.b_sel = OPB_E;
                         cmd.b_idx = 2'd1; end
            4'd11: begin cmd.a_sel = OPA_N; cmd.a_idx = 2'd2; cmd.b_sel = OPB_E;
                         cmd.b_idx = 2'd2; cmd.dst = DST_NE; end
            default: cmd.mac = 1'b0;
          endcase
        end else begin
          // four dot products of three terms each
          cmd.a_idx = (step < 4'd3) ? 2'(step) : (step < 4'd6) ? 2'(step - 4'd3) :
                      (step < 4'd9) ? 2'(step - 4'd6) : 2'(step - 4'd9);
          cmd.b_idx = cmd.a_idx;
          cmd.clr   = (cmd.a_idx == 2'd0);
          if (step < 4'd3) begin
            cmd.a_sel = OPA_AM; cmd.b_sel = OPB_AB;
            cmd.dst   = (step == 4'd2) ? DST_PAB : DST_NONE;
          end else if (step < 4'd6) begin
            cmd.a_sel = OPA_AM; cmd.b_sel = OPB_AD;
            cmd.dst   = (step == 4'd5) ? DST_PAD : DST_NONE;
          end else if (step < 4'd9) begin
            cmd.a_sel = OPA_AB; cmd.b_sel = OPB_AB;
            cmd.dst   = (step == 4'd8) ? DST_AAB : DST_NONE;
          end else begin
            cmd.a_sel = OPA_AD; cmd.b_sel = OPB_AD;
            cmd.dst   = (step == 4'd11) ? DST_AAD : DST_NONE;
          end
        end
      end
      S_CHECK: cmd.fin_par = stat.ne_zero;
      S_NUMHI: begin
        cmd.mac = 1'b1; cmd.a_sel = OPA_DHI; cmd.b_sel = OPB_EABS;
        cmd.b_idx = coord; cmd.clr = 1'b1;
      end
      S_NUMLO: begin
        cmd.mac = 1'b1; cmd.a_sel = OPA_DLO; cmd.b_sel = OPB_EABS;
        cmd.b_idx = coord; cmd.shift = 1'b1;
      end
      S_DIVGO: cmd.div_start = 1'b1;
      S_DIVW:  cmd.m_store = stat.div_done;
      S_FIN:   cmd.fin_hit = 1'b1;
      default: cmd.mac = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/rhit_dp.sv
`default_nettype none
module rhit_dp
  import rhit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  rhit_in_t  item,
  input  rhit_cmd_t cmd,
  output rhit_stat_t stat,
  output rhit_out_t result
);

  localparam int W    = COORD_WIDTH;
  localparam int UW   = W + 1;
  localparam int NW   = 2 * W + 3;
  localparam int MAW  = (NW > 34) ? NW : 34;
  localparam int MBW  = W + 1;
  localparam int PW   = MAW + MBW;
  localparam int DLO  = MAW - 1;
  localparam int ACW  = (4 * W + 6 > PW + 2) ? 4 * W + 6 : PW + 2;
  localparam int XW   = (W > 16) ? W : 16;

  logic signed [W-1:0]   c [4][3];
  logic signed [W-1:0]   e [3];
  logic signed [NW-1:0]  n [3];
  logic signed [31:0]    m [3];
  logic signed [ACW-1:0] d_r, ne_r, pab, pad, aab, aad, acc, acc_next;

  logic signed [UW-1:0]  u [3], v [3], ab [3], ad [3];
  logic signed [33:0]    am [3];
  logic signed [MBW-1:0] eabs [3];
  logic [ACW-1:0]        absd, absne, dsh, quot;
  logic signed [MAW-1:0] opa;
  logic signed [MBW-1:0] opb;
  logic signed [PW-1:0]  prod;
  logic signed [ACW-1:0] pext;
  logic [1:0]            ai, bi;
  logic                  div_done;
  logic                  eneg;
  logic [31:0]           lim, mag;

  // low W bits of a field, sign taken from bit W-1
  function automatic logic signed [W-1:0] coord_of(input logic [15:0] f);
    logic [XW-1:0] t;
    t = XW'(f);
    return t[W-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i]    = UW'(c[2][i]) - UW'(c[1][i]);
      v[i]    = UW'(c[0][i]) - UW'(c[1][i]);
      ab[i]   = UW'(c[1][i]) - UW'(c[0][i]);
      ad[i]   = UW'(c[3][i]) - UW'(c[0][i]);
      am[i]   = 34'(m[i]) - 34'(c[0][i]);
      eabs[i] = e[i][W-1] ? -MBW'(e[i]) : MBW'(e[i]);
    end
  end

  assign absd  = d_r[ACW-1] ? ACW'(-d_r) : ACW'(d_r);
  assign absne = ne_r[ACW-1] ? ACW'(-ne_r) : ACW'(ne_r);
  assign dsh   = absd >> DLO;
  assign ai    = (cmd.a_idx == 2'd3) ? 2'd2 : cmd.a_idx;
  assign bi    = (cmd.b_idx == 2'd3) ? 2'd2 : cmd.b_idx;

  always_comb begin
    case (cmd.a_sel)
      OPA_U:   opa = MAW'(u[ai]);
      OPA_N:   opa = MAW'(n[ai]);
      OPA_DLO: opa = {1'b0, absd[DLO-1:0]};
      OPA_DHI: opa = dsh[MAW-1:0];
      OPA_AM:  opa = MAW'(am[ai]);
      OPA_AB:  opa = MAW'(ab[ai]);
      OPA_AD:  opa = MAW'(ad[ai]);
      default: opa = '0;
    endcase
    case (cmd.b_sel)
      OPB_V:    opb = v[bi];
      OPB_C1:   opb = MBW'(c[1][bi]);
      OPB_E:    opb = MBW'(e[bi]);
      OPB_EABS: opb = eabs[bi];
      OPB_AB:   opb = ab[bi];
      OPB_AD:   opb = ad[bi];
      default:  opb = '0;
    endcase
  end

  assign prod     = opa * opb;
  assign pext     = ACW'(prod);
  assign acc_next = (cmd.clr ? '0 : (cmd.shift ? (acc <<< DLO) : acc))
                    + (cmd.neg ? -pext : pext);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          c[k][i] <= '0;
        end
      end
    end else if (cmd.load) begin
      c[item.corner][0] <= coord_of(item.px);
      c[item.corner][1] <= coord_of(item.py);
      c[item.corner][2] <= coord_of(item.pz);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      e[0] <= coord_of(item.px);
      e[1] <= coord_of(item.py);
      e[2] <= coord_of(item.pz);
    end
    if (cmd.mac) begin
      acc <= acc_next;
      case (cmd.dst)
        DST_N0:  n[0] <= NW'(acc_next);
        DST_N1:  n[1] <= NW'(acc_next);
        DST_N2:  n[2] <= NW'(acc_next);
        DST_D:   d_r  <= acc_next;
        DST_NE:  ne_r <= acc_next;
        DST_PAB: pab  <= acc_next;
        DST_PAD: pad  <= acc_next;
        DST_AAB: aab  <= acc_next;
        DST_AAD: aad  <= acc_next;
        default: ;
      endcase
    end
    if (cmd.m_store) begin
      m[cmd.coord] <= eneg ? -$signed(mag) : $signed(mag);
    end
    if (cmd.fin_par) begin
      result <= '{hit: 1'b0, parallel: 1'b1, ix: '0, iy: '0, iz: '0};
    end else if (cmd.fin_hit) begin
      result.hit      <= (pab > 0) && (pab < aab) && (pad > 0) && (pad < aad);
      result.parallel <= 1'b0;
      result.ix       <= m[0];
      result.iy       <= m[1];
      result.iz       <= m[2];
    end
  end

  // saturate the quotient magnitude; the negative side reaches one further
  assign eneg = e[(cmd.coord == 2'd3) ? 2'd2 : cmd.coord][W-1];
  assign lim  = eneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mag  = (quot > ACW'(lim)) ? lim : quot[31:0];

  rhit_div #(.WIDTH(ACW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (ACW'(acc <<< 1) + absne),
    .den   (absne << 1),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.ne_zero  = (ne_r == '0);
  assign stat.div_done = div_done;

endmodule
`default_nettype wire

### hw/rtl/ray_rectangle_hit_test.sv
// Load word: stored in the corner registers when accepted, no result; busy stays low.
// Test word: setup, parallel check, an ACW-bit division per coordinate, hit test; ACW =
// max(4*COORD_WIDTH+6, COORD_WIDTH+37) (70 at the default width); parallel rays end there.
// The time goes to the bit-serial divider, one quotient bit per cycle for each coordinate.
// One test at a time: a new word is taken in the cycle that done is shown.
// Synchronous reset clears the control state and all four corners to zero.
`default_nettype none
module ray_rectangle_hit_test
  import rhit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  rhit_in_t  item,
  output logic      done,
  output rhit_out_t result
);

  rhit_cmd_t  cmd;
  rhit_stat_t stat;

  rhit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item_cmd (item.cmd),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  rhit_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule
`default_nettype wire

### hw/rtl/rhit_chk.sv
`default_nettype none
module rhit_chk
  import rhit_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input rhit_in_t  item,
  input wire logic done,
  input rhit_out_t result
);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word shown while still busy");

  a_par_nohit: assert property (@(posedge clk) disable iff (rst)
    done && result.parallel |-> !result.hit && result.ix == 0)
    else $error("parallel result carries a hit or a point");

  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == CMD_TEST |=> busy && !done)
    else $error("test word not started");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == CMD_LOAD |=> !busy && !done)
    else $error("load word caused activity");

endmodule

bind ray_rectangle_hit_test rhit_chk u_rhit_chk (.*);
`default_nettype wire
